FILE: hdl/bitmap_contiguous_run_allocator_defines.svh
// Assertion macros used by the checker file of the run allocator.
`ifndef BITMAP_CONTIGUOUS_RUN_ALLOCATOR_DEFINES_SVH
`define BITMAP_CONTIGUOUS_RUN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is low.
`define BCRA_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("run allocator check failed");

// Next-cycle implication, sampled on the rising edge, off while reset is low.
`define BCRA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("run allocator check failed");

`endif

FILE: hdl/bcra_pkg.sv
`default_nettype none

package bcra_pkg;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_RESERVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_SPACE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_MARK_RD,
        S_MARK,
        S_RES_OK,
        S_RES_INVAL,
        S_RES_FULL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clr_en;
        logic    load_en;
        logic    take_req;
        logic    start_en;
        logic    scan_en;
        logic    mark_first;
        logic    mark_en;
        logic    out_load;
        logic    commit_ok;
        t_status out_code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic req_zero;
        logic hint_bad;
        logic scan_ok;
        logic scan_fail;
        logic mark_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: hdl/bcra_ram.sv
`default_nettype none

module bcra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire  logic                     i_clk,
    input  wire  logic                     i_we,
    input  wire  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  logic [WIDTH-1:0]         i_wdata,
    input  wire  logic                     i_re,
    input  wire  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic       [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/bcra_dp.sv
`default_nettype none

module bcra_dp #(
    parameter int MAP_BITS  = 32768,
    parameter int WORD_BITS = 64
) (
    input  wire  logic                 i_clk,
    input  wire  logic                 i_rst_n,
    input  wire  bcra_pkg::t_cmd       i_cmd,
    output bcra_pkg::t_stat            o_stat,
    input  wire  logic                 i_cfg_we,
    input  wire  logic [15:0]          i_cfg_wdata,
    input  wire  logic [8:0]           i_word_index,
    input  wire  logic [WORD_BITS-1:0] i_word_bits,
    input  wire  logic [15:0]          i_request_count,
    input  wire  logic                 i_out_ready,
    output logic                       o_out_valid,
    output logic [1:0]                 o_status,
    output logic [14:0]                o_first_page,
    output logic [15:0]                o_page_count,
    output logic [31:0]                o_reservations_total
);

    localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int ID_W      = $clog2(MAP_BITS) + 1;
    localparam int SUM_W     = ((ID_W > 16) ? ID_W : 16) + 1;
    localparam logic [SUM_W-1:0] MAP_END   = SUM_W'(MAP_BITS);
    localparam logic [SUM_W-1:0] WORD_STEP = SUM_W'(WORD_BITS);
    localparam logic [SUM_W-1:0] WORD_CNT  = SUM_W'(MAP_WORDS);
    localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [BW:0]      WORD_LEN  = (BW + 1)'(WORD_BITS);

    function automatic logic [BW-1:0] lowest_set(input logic [WORD_BITS-1:0] m);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (m[BW'(i)]) begin
                idx = BW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [WORD_BITS-1:0] ones_below(input logic [BW:0] n);
        logic [WORD_BITS:0] t;
        t = ({{WORD_BITS{1'b0}}, 1'b1} << n) - {{WORD_BITS{1'b0}}, 1'b1};
        return t[WORD_BITS-1:0];
    endfunction

    // Control registers.
    logic [AW-1:0]    r_clr_addr;
    logic [SUM_W-1:0] r_hint;
    logic [31:0]      r_counter;
    logic             r_out_valid;

    // Working registers of one transaction.
    logic [15:0]      r_count;
    logic [SUM_W-1:0] r_pos;
    logic             r_in_run;
    logic [SUM_W-1:0] r_run_start;
    logic [SUM_W-1:0] r_run_len;
    logic [AW-1:0]    r_mark_addr;
    logic [BW-1:0]    r_mark_pos;
    logic [SUM_W-1:0] r_mark_left;

    // Result register.
    bcra_pkg::t_status r_status;
    logic [14:0]       r_first;
    logic [15:0]       r_pcount;
    logic [31:0]       r_total;

    logic [WORD_BITS-1:0] ram_q;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;

    logic [BW-1:0]        scan_b;
    logic [WORD_BITS-1:0] from_m;
    logic [WORD_BITS-1:0] sel_m;
    logic                 hit;
    logic [BW-1:0]        hit_idx;
    logic [SUM_W-1:0]     word_base;
    logic [SUM_W-1:0]     next_base;
    logic [SUM_W-1:0]     hit_pos;
    logic [BW:0]          avail;
    logic [SUM_W-1:0]     run_sum;
    logic [SUM_W-1:0]     req_ext;
    logic [SUM_W-1:0]     n_pos;
    logic                 n_in_run;
    logic [SUM_W-1:0]     n_run_start;
    logic [SUM_W-1:0]     n_run_len;
    logic                 scan_ok;
    logic                 scan_fail;
    logic                 scan_rd;

    logic [BW:0]          mark_room;
    logic                 mark_last;
    logic [BW:0]          mark_len;
    logic [WORD_BITS-1:0] mark_mask;

    logic                 load_ok;
    logic [31:0]          n_counter;

    assign req_ext   = SUM_W'(r_count);
    assign n_counter = (&r_counter) ? r_counter : r_counter + 32'd1;
    assign load_ok   = i_cmd.load_en && (SUM_W'(i_word_index) < WORD_CNT);

    // One scan step: jump from the current position to the next change between
    // free and taken inside the current word, or to the start of the next word.
    always_comb begin
        scan_b    = r_pos[BW-1:0];
        from_m    = {WORD_BITS{1'b1}} << scan_b;
        sel_m     = r_in_run ? (ram_q & from_m) : (~ram_q & from_m);
        hit       = |sel_m;
        hit_idx   = lowest_set(sel_m);
        word_base = {r_pos[SUM_W-1:BW], {BW{1'b0}}};
        next_base = word_base + WORD_STEP;
        hit_pos   = word_base + SUM_W'(hit_idx);
        avail     = hit ? ({1'b0, hit_idx} - {1'b0, scan_b}) : (WORD_LEN - {1'b0, scan_b});
        run_sum   = r_run_len + SUM_W'(avail);

        n_pos       = r_pos;
        n_in_run    = r_in_run;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        scan_ok     = 1'b0;
        scan_fail   = 1'b0;

        if (!r_in_run) begin
            if (!hit) begin
                n_pos     = next_base;
                scan_fail = (next_base >= MAP_END);
            end else begin
                // A run that cannot fit before the end of the map ends the search.
                scan_fail   = ((hit_pos + req_ext) > MAP_END);
                n_in_run    = 1'b1;
                n_run_start = hit_pos;
                n_run_len   = '0;
                n_pos       = hit_pos;
            end
        end else begin
            if (run_sum >= req_ext) begin
                scan_ok = 1'b1;
            end else if (!hit) begin
                n_run_len = run_sum;
                n_pos     = next_base;
                scan_fail = (next_base >= MAP_END);
            end else begin
                n_in_run = 1'b0;
                n_pos    = hit_pos + SUM_W'(1);
            end
        end

        scan_rd = (n_pos[SUM_W-1:BW] != r_pos[SUM_W-1:BW]);
    end

    always_comb begin
        mark_room = WORD_LEN - {1'b0, r_mark_pos};
        mark_last = (r_mark_left <= SUM_W'(mark_room));
        mark_len  = mark_last ? r_mark_left[BW:0] : mark_room;
        mark_mask = ({WORD_BITS{1'b1}} << r_mark_pos)
                  & ones_below({1'b0, r_mark_pos} + mark_len);
    end

    always_comb begin
        ram_we    = i_cmd.clr_en || load_ok || i_cmd.mark_en;
        ram_waddr = r_mark_addr;
        ram_wdata = ram_q | mark_mask;
        if (i_cmd.clr_en) begin
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (i_cmd.load_en) begin
            ram_waddr = AW'(i_word_index);
            ram_wdata = i_word_bits;
        end

        ram_re    = i_cmd.start_en || (i_cmd.scan_en && scan_rd)
                 || i_cmd.mark_first || i_cmd.mark_en;
        ram_raddr = n_pos[BW +: AW];
        if (i_cmd.start_en) begin
            ram_raddr = r_hint[BW +: AW];
        end else if (i_cmd.mark_first) begin
            ram_raddr = r_run_start[BW +: AW];
        end else if (i_cmd.mark_en) begin
            ram_raddr = r_mark_addr + AW'(1);
        end
    end

    bcra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_hint      <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_hint <= SUM_W'(i_cfg_wdata);
            end else if (i_cmd.commit_ok) begin
                r_hint <= r_run_start + req_ext;
            end
            if (i_cmd.commit_ok) begin
                r_counter <= n_counter;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_count <= i_request_count;
        end
        if (i_cmd.start_en) begin
            r_pos    <= r_hint;
            r_in_run <= 1'b0;
        end else if (i_cmd.scan_en) begin
            r_pos       <= n_pos;
            r_in_run    <= n_in_run;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
        end
        if (i_cmd.mark_first) begin
            r_mark_addr <= r_run_start[BW +: AW];
            r_mark_pos  <= r_run_start[BW-1:0];
            r_mark_left <= req_ext;
        end else if (i_cmd.mark_en) begin
            r_mark_addr <= r_mark_addr + AW'(1);
            r_mark_pos  <= '0;
            r_mark_left <= r_mark_left - SUM_W'(mark_len);
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_code;
            r_first  <= i_cmd.commit_ok ? r_run_start[14:0] : 15'd0;
            r_pcount <= i_cmd.commit_ok ? r_count : 16'd0;
            r_total  <= i_cmd.commit_ok ? n_counter : r_counter;
        end
    end

    assign o_stat.clr_last  = (r_clr_addr == LAST_WORD);
    assign o_stat.req_zero  = (i_request_count == 16'd0);
    assign o_stat.hint_bad  = (r_hint >= MAP_END);
    assign o_stat.scan_ok   = scan_ok;
    assign o_stat.scan_fail = scan_fail;
    assign o_stat.mark_last = mark_last;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_status;
    assign o_first_page         = r_first;
    assign o_page_count         = r_pcount;
    assign o_reservations_total = r_total;

endmodule

`default_nettype wire

FILE: hdl/bcra_ctrl.sv
`default_nettype none

module bcra_ctrl (
    input  wire  logic            i_clk,
    input  wire  logic            i_rst_n,
    input  wire  logic            i_in_valid,
    input  wire  logic            i_operation,
    input  wire  bcra_pkg::t_stat i_stat,
    output logic                  o_in_ready,
    output bcra_pkg::t_cmd        o_cmd
);

    bcra_pkg::t_state r_state;
    bcra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcra_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bcra_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = bcra_pkg::S_IDLE;
                end
            end
            bcra_pkg::S_IDLE: begin
                if (i_in_valid && (i_operation == bcra_pkg::OP_RESERVE)) begin
                    n_state = i_stat.req_zero ? bcra_pkg::S_RES_INVAL : bcra_pkg::S_START;
                end
            end
            bcra_pkg::S_START: begin
                n_state = i_stat.hint_bad ? bcra_pkg::S_RES_FULL : bcra_pkg::S_SCAN;
            end
            bcra_pkg::S_SCAN: begin
                if (i_stat.scan_ok) begin
                    n_state = bcra_pkg::S_MARK_RD;
                end else if (i_stat.scan_fail) begin
                    n_state = bcra_pkg::S_RES_FULL;
                end
            end
            bcra_pkg::S_MARK_RD: begin
                n_state = bcra_pkg::S_MARK;
            end
            bcra_pkg::S_MARK: begin
                if (i_stat.mark_last) begin
                    n_state = bcra_pkg::S_RES_OK;
                end
            end
            bcra_pkg::S_RES_OK, bcra_pkg::S_RES_INVAL, bcra_pkg::S_RES_FULL: begin
                if (i_stat.out_free) begin
                    n_state = bcra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bcra_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_code = bcra_pkg::ST_OK;
        case (r_state)
            bcra_pkg::S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            bcra_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_en  = (i_operation == bcra_pkg::OP_LOAD);
                    o_cmd.take_req = (i_operation == bcra_pkg::OP_RESERVE);
                end
            end
            bcra_pkg::S_START: begin
                o_cmd.start_en = 1'b1;
            end
            bcra_pkg::S_SCAN: begin
                o_cmd.scan_en = 1'b1;
            end
            bcra_pkg::S_MARK_RD: begin
                o_cmd.mark_first = 1'b1;
            end
            bcra_pkg::S_MARK: begin
                o_cmd.mark_en = 1'b1;
            end
            bcra_pkg::S_RES_OK: begin
                o_cmd.out_load  = i_stat.out_free;
                o_cmd.commit_ok = i_stat.out_free;
                o_cmd.out_code  = bcra_pkg::ST_OK;
            end
            bcra_pkg::S_RES_INVAL: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_code = bcra_pkg::ST_INVALID;
            end
            bcra_pkg::S_RES_FULL: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_code = bcra_pkg::ST_NO_SPACE;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/bitmap_contiguous_run_allocator.sv
// Contiguous page-run allocator over a bitmap (set bit = page allocated).
// Input channel (i_in_valid / o_in_ready): a load transaction writes one bitmap
// word and leaves the block idle; a reserve transaction asks for i_request_count
// consecutive free pages, searched first-fit from the search hint.
// Output channel (o_out_valid / i_out_ready): one result per reserve, none per
// load. The result sits in an output register, so a stalled receiver does not
// block the next load; a reserve that finishes while the register is still
// full waits in its result state until the receiver takes the old result.
// A reserve reads the hint word, then scans the bitmap word by word and free run
// by free run, then reads the first word of the run and marks the run word by
// word, and posts the result from its result state. A zero request goes
// straight to its result state, a hint past the map after the hint-word read.
// The scan and marking share the single bitmap memory, so one reserve is in
// flight at a time. i_cfg_we loads the search hint at once; the user must
// assert it only while the block is idle, which the block does not enforce.
// Reset clears the hint and the counter, then a clearing pass writes every
// bitmap word to free, with o_in_ready held low.
`default_nettype none

module bitmap_contiguous_run_allocator #(
    parameter int MAP_BITS  = 32768,
    parameter int WORD_BITS = 64
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_cfg_we,
    input  wire  logic [15:0] i_cfg_wdata,
    input  wire  logic        i_in_valid,
    output logic              o_in_ready,
    input  wire  logic        i_operation,
    input  wire  logic [8:0]  i_word_index,
    input  wire  logic [63:0] i_word_bits,
    input  wire  logic [15:0] i_request_count,
    output logic              o_out_valid,
    input  wire  logic        i_out_ready,
    output logic [1:0]        o_status,
    output logic [14:0]       o_first_page,
    output logic [15:0]       o_page_count,
    output logic [31:0]       o_reservations_total
);

    bcra_pkg::t_cmd  cmd;
    bcra_pkg::t_stat stat;

    bcra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    bcra_dp #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_word_index         (i_word_index),
        .i_word_bits          (i_word_bits[WORD_BITS-1:0]),
        .i_request_count      (i_request_count),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_status             (o_status),
        .o_first_page         (o_first_page),
        .o_page_count         (o_page_count),
        .o_reservations_total (o_reservations_total)
    );

endmodule

`default_nettype wire

FILE: hdl/bcra_chk.sv
`default_nettype none
`include "bitmap_contiguous_run_allocator_defines.svh"

module bcra_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_status,
    input wire logic [14:0] i_first_page,
    input wire logic [15:0] i_page_count,
    input wire logic [31:0] i_total
);

    // A result waiting on the receiver keeps its contents.
    `BCRA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_first_page) && $stable(i_page_count) && $stable(i_total))

    // Error results carry no run.
    `BCRA_ASSERT_SAME(a_err_empty, i_clk, i_rst_n, i_out_valid && (i_status != bcra_pkg::ST_OK), (i_first_page == 15'd0) && (i_page_count == 16'd0))

    // A granted run is never empty and has been counted.
    `BCRA_ASSERT_SAME(a_ok_counted, i_clk, i_rst_n, i_out_valid && (i_status == bcra_pkg::ST_OK), (i_page_count != 16'd0) && (i_total != 32'd0))

    // The bitmap clearing pass holds off transactions right after reset.
    `BCRA_ASSERT_SAME(a_clear_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !i_in_ready)

endmodule

bind bitmap_contiguous_run_allocator bcra_chk u_bcra_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (o_in_ready),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_status     (o_status),
    .i_first_page (o_first_page),
    .i_page_count (o_page_count),
    .i_total      (o_reservations_total)
);

`default_nettype wire

FILE: bench/bitmap_contiguous_run_allocator_tb.sv
`timescale 1ns / 1ps

module bitmap_contiguous_run_allocator_tb;

    localparam int MAP_PAGES     = 32768;
    localparam int PAGE_WORDS    = 512;
    localparam int RANDOM_ITEMS  = 1380;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic        op;
        logic [8:0]  word_index;
        logic [63:0] word_bits;
        logic [15:0] request_count;
    } t_alloc_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] first_page;
        logic [15:0] page_count;
        logic [31:0] total;
    } t_alloc_reply;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [15:0] cfg_wdata     = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        operation     = bcra_pkg::OP_LOAD;
    logic [8:0]  word_index    = '0;
    logic [63:0] word_bits     = '0;
    logic [15:0] request_count = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [1:0]  out_status;
    logic [14:0] out_first_page;
    logic [15:0] out_page_count;
    logic [31:0] out_total;

    // Shadow copy of the allocator state.
    logic [63:0] page_map [PAGE_WORDS];
    logic [15:0] run_hint;
    logic [31:0] grant_total;

    t_alloc_req   request_queue[$];
    t_alloc_reply expected_replies[$];
    t_alloc_req   active_req;
    t_alloc_reply expected_head;

    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_left    = 0;
    int stall_orders = 0;
    int stall_served = 0;
    int error_count  = 0;
    int idle_cycles  = 0;
    bit send_idles   = 1'b0;
    bit recv_idles   = 1'b0;

    bitmap_contiguous_run_allocator uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_wdata         (cfg_wdata),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_operation         (operation),
        .i_word_index        (word_index),
        .i_word_bits         (word_bits),
        .i_request_count     (request_count),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_status            (out_status),
        .o_first_page        (out_first_page),
        .o_page_count        (out_page_count),
        .o_reservations_total(out_total)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit page_busy(input int unsigned id);
        if (id >= MAP_PAGES) return 1'b1;
        return page_map[9'(id / 64)][6'(id % 64)];
    endfunction

    // First-fit search from the hint; a failed candidate resumes just past
    // the allocated page that broke it.
    function automatic t_alloc_reply reserve_run(input logic [15:0] count);
        t_alloc_reply reply;
        int unsigned  cand;
        int unsigned  start;
        int unsigned  run;
        int unsigned  idx;
        bit           done;
        reply.status     = bcra_pkg::ST_NO_SPACE;
        reply.first_page = '0;
        reply.page_count = '0;
        if (count == 16'd0) begin
            reply.status = bcra_pkg::ST_INVALID;
        end else begin
            cand = 32'(run_hint);
            done = 1'b0;
            while (!done) begin
                while (cand < MAP_PAGES && page_busy(cand)) cand++;
                if (cand >= MAP_PAGES || cand + count > MAP_PAGES) begin
                    done = 1'b1;
                end else begin
                    start = cand;
                    run = 0;
                    while (run < count && !page_busy(start + run)) run++;
                    if (run == count) begin
                        for (idx = 0; idx < count; idx++) begin
                            page_map[9'((start + idx) / 64)][6'((start + idx) % 64)] = 1'b1;
                        end
                        run_hint = 16'(start + count);
                        if (grant_total != '1) grant_total++;
                        reply.status     = bcra_pkg::ST_OK;
                        reply.first_page = start[14:0];
                        reply.page_count = count;
                        done = 1'b1;
                    end else begin
                        cand = start + run + 1;
                    end
                end
            end
        end
        reply.total = grant_total;
        return reply;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 1) return 16'd0;
        if (r < 70) return 16'($urandom_range(1, 16));
        if (r < 90) return 16'($urandom_range(17, 200));
        if (r < 98) return 16'($urandom_range(201, 4096));
        return 16'($urandom_range(0, MAP_PAGES));
    endfunction

    function automatic logic [63:0] pick_word();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 50) return '0;
        if (r < 75) return {$urandom, $urandom};
        if (r < 88) return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        if (r < 95) return '1;
        return ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
    endfunction

    function automatic t_alloc_req make_load(input int idx, input logic [63:0] bits);
        t_alloc_req req;
        req.op            = bcra_pkg::OP_LOAD;
        req.word_index    = 9'(idx);
        req.word_bits     = bits;
        req.request_count = '0;
        return req;
    endfunction

    function automatic t_alloc_req make_reserve(input logic [15:0] count);
        t_alloc_req req;
        req.op            = bcra_pkg::OP_RESERVE;
        req.word_index    = 9'($urandom_range(0, PAGE_WORDS - 1));
        req.word_bits     = {$urandom, $urandom};
        req.request_count = count;
        return req;
    endfunction

    task automatic add_request(input t_alloc_req req);
        request_queue.insert(request_queue.size(), req);
    endtask

    task automatic present_next();
        active_req = request_queue.pop_front();
        in_valid      <= 1'b1;
        operation     <= active_req.op;
        word_index    <= active_req.word_index;
        word_bits     <= active_req.word_bits;
        request_count <= active_req.request_count;
    endtask

    // Loads give no result, so a settling pause lets the last one land.
    // The check is repeated after the pause in case the driver took the last
    // item from the queue in the same time step as the first check.
    task automatic wait_drained();
        do begin
            while (request_queue.size() != 0 || in_valid || expected_replies.size() != 0) begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end while (request_queue.size() != 0 || in_valid || expected_replies.size() != 0
                   || !in_ready);
    endtask

    task automatic write_hint(input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        run_hint  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver: the shadow state is updated when the transaction is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && in_ready) begin
            if (active_req.op == bcra_pkg::OP_LOAD) begin
                page_map[active_req.word_index] = active_req.word_bits;
            end else begin
                expected_replies.insert(expected_replies.size(),
                                        reserve_run(active_req.request_count));
            end
            send_gap = (send_idles && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
            if (send_gap == 0 && request_queue.size() != 0) begin
                present_next();
            end else begin
                in_valid <= 1'b0;
            end
        end else if (!in_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (request_queue.size() != 0) begin
                present_next();
            end
        end
    end

    // Monitor: checks each result and paces the receiver side.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_replies.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("unexpected result: status=%0d first=%0d count=%0d total=%0d",
                                 out_status, out_first_page, out_page_count, out_total);
                    end
                end else begin
                    expected_head = expected_replies.pop_front();
                    if (out_status !== expected_head.status ||
                        out_first_page !== expected_head.first_page ||
                        out_page_count !== expected_head.page_count ||
                        out_total !== expected_head.total) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("mismatch: expected status=%0d first=%0d count=%0d total=%0d",
                                     expected_head.status, expected_head.first_page,
                                     expected_head.page_count, expected_head.total);
                            $display("          actual   status=%0d first=%0d count=%0d total=%0d",
                                     out_status, out_first_page, out_page_count, out_total);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_served != stall_orders) begin
                stall_served++;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else if (recv_idles && $urandom_range(0, 3) == 0) begin
                recv_gap = pick_gap() - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int          w;
        int          k;
        int          phase;
        int          win_word;
        int          win_len;
        int          body_len;
        int          random_sent;
        logic [15:0] hint_value;

        for (w = 0; w < PAGE_WORDS; w++) page_map[w] = '0;
        run_hint    = '0;
        grant_total = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty map from reset: the whole map in one run, then a zero request
        // and a search that starts at the map's end.
        add_request(make_reserve(16'd32768));
        add_request(make_reserve(16'd0));
        add_request(make_reserve(16'd1));
        add_request(make_load(0, 64'd0));
        add_request(make_load(PAGE_WORDS - 1, 64'd0));
        add_request(make_load(256, 64'hAAAA_AAAA_AAAA_AAAA));
        add_request(make_load(257, 64'h5555_5555_5555_5555));
        wait_drained();

        write_hint(16'd32767);
        add_request(make_reserve(16'd1));
        add_request(make_reserve(16'd1));
        wait_drained();

        write_hint(16'd32768);
        add_request(make_reserve(16'd5));
        wait_drained();

        write_hint(16'd0);
        add_request(make_reserve(16'd64));
        add_request(make_reserve(16'd1));
        add_request(make_reserve(16'd2));
        add_request(make_load(0, '1));
        add_request(make_load(PAGE_WORDS - 1, '1));
        add_request(make_reserve(16'd1000));
        add_request(make_reserve(16'd32767));

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_drained();
            send_idles = (phase % 3) != 0;
            recv_idles = (phase % 2) != 0;
            win_len  = int'($urandom_range(4, 16));
            win_word = int'($urandom_range(0, PAGE_WORDS - win_len));
            if (phase == 4) begin
                hint_value = 16'd32768;
            end else if (phase == 6) begin
                hint_value = 16'd32767;
            end else if ($urandom_range(0, 3) == 0) begin
                hint_value = 16'($urandom_range(0, MAP_PAGES));
            end else begin
                hint_value = 16'(win_word * 64);
            end
            write_hint(hint_value);
            if (phase == 1) stall_orders++;

            // Reload a window of words first so that most reserves that follow can land.
            for (k = 0; k < win_len; k++) begin
                add_request(make_load(win_word + k, pick_word()));
            end
            body_len = int'($urandom_range(60, 100));
            for (k = 0; k < body_len; k++) begin
                if (k == body_len / 2 && (phase == 2 || $urandom_range(0, 2) == 0)) begin
                    wait_drained();
                end
                if ($urandom_range(0, 99) < 70) begin
                    add_request(make_reserve(pick_count()));
                end else if ($urandom_range(0, 99) < 20) begin
                    add_request(make_load(int'($urandom_range(0, PAGE_WORDS - 1)),
                                          pick_word()));
                end else begin
                    add_request(make_load(win_word + int'($urandom_range(0, win_len - 1)),
                                          pick_word()));
                end
            end
            random_sent += win_len + body_len;
            phase++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        error_count += expected_replies.size();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
